// File: hdl/gen_laguerre_poly_eval_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the generalized Laguerre evaluator
// Implication checks sampled on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef GEN_LAGUERRE_POLY_EVAL_TOP_MACROS_SVH
`define GEN_LAGUERRE_POLY_EVAL_TOP_MACROS_SVH

// same-cycle implication
`define GLP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/glp_pkg.sv
// ---------------------------------------------------------------------------
// glp_pkg
// Shared constants and types of the Laguerre evaluator.
// ---------------------------------------------------------------------------
package glp_pkg;
	localparam int MAX_ORDER_DEF = 16;
	localparam int NUM_BYTES     = 14;
	localparam int NUM_W         = 8 * NUM_BYTES;

	typedef struct packed {
		logic busy;
		logic done;
	} glp_div_stat_t;
endpackage

// File: hdl/gen_laguerre_poly_eval_top.sv
// ---------------------------------------------------------------------------
// gen_laguerre_poly_eval_top
// Generalized Laguerre polynomial with first and second derivative.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel: write alpha (signed Q16.16) while the block is idle.
//   s_axis: one transaction holds x_point (unsigned Q16.16) and poly_order.
//   m_axis: one transaction per input with value, first and second
//   derivative (signed Q32.32) and the overflow flag in tuser.
// Steps: orders 0 and 1 need no recurrence step; each recurrence step
//   works out three values in turn, each on the shared 35x17 multiplier,
//   then a setup state and the byte-serial divider row, and ends in the
//   step state, so an order n item takes n-1 recurrence steps.
// One item is in work at a time; the next is taken once the result is in
//   the output register, so a stalled receiver holds one result and the
//   block stalls only when a second result is ready.
// Reset clears alpha to zero and empties the output register.
// ---------------------------------------------------------------------------
module gen_laguerre_poly_eval_top #(
	parameter int MAX_ORDER = glp_pkg::MAX_ORDER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,      // alpha
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // x_point[31:0], poly_order[36:32], zero
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // poly_value, first_derivative,
	                                    // second_derivative
	output logic [0:0]   m_axis_tuser   // overflow
);
	import glp_pkg::*;
`include "gen_laguerre_poly_eval_top_macros.svh"

	localparam int IW = $clog2(MAX_ORDER + 2);
	localparam int OW = (IW > 5) ? IW : 5;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SEL  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DVS  = 5'b01000,
		ST_DIV  = 5'b10000
	} state_t;

	state_t state_q;
	logic signed [31:0] alpha_q;
	logic        [31:0] x_q;
	logic [IW-1:0] n_q, i_q;
	logic [1:0]    j_q;
	logic [3:0]    mcnt_q;
	logic signed [63:0] cur_q [3];
	logic signed [63:0] prv_q [3];
	logic signed [63:0] nxt_q [3];
	logic signed [34:0] c_q, d_q;
	logic signed [127:0] acc_q;
	logic        ov_q;
	logic signed [51:0] prod_s1;
	logic [1:0]  psh_s1;
	logic        psub_s1, pv_s1;
	logic        out_valid_q;
	logic [191:0] out_data_q;
	logic        out_ov_q;

	logic        in_acc_c, out_free_c;
	logic [OW-1:0] ord_c;
	logic [IW-1:0] n_c;
	logic signed [34:0] coef_c;
	logic signed [63:0] op_c;
	logic signed [16:0] chunk_c;
	logic signed [51:0] prod_c;
	logic signed [127:0] term_c, acc_init_c, mag_c;
	logic [NUM_W-1:0] quo_c;
	glp_div_stat_t div_stat;
	logic signed [63:0] sat_c;
	logic        sat_ov_c;
	logic signed [34:0] x_ext_c, a_ext_c;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc_c      = s_axis_tvalid && s_axis_tready;
	assign out_free_c    = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ov_q;

	assign ord_c = OW'(s_axis_tdata[36:32]);
	assign n_c   = (ord_c > OW'(MAX_ORDER)) ? IW'(MAX_ORDER) : IW'(ord_c);

	assign x_ext_c = 35'(signed'({1'b0, x_q}));
	assign a_ext_c = 35'(alpha_q);

	assign coef_c = mcnt_q[2] ? d_q : c_q;
	assign op_c   = mcnt_q[2] ? prv_q[j_q] : cur_q[j_q];

	always_comb begin
		case (mcnt_q[1:0])
			2'd0:    chunk_c = signed'({1'b0, op_c[15:0]});
			2'd1:    chunk_c = signed'({1'b0, op_c[31:16]});
			2'd2:    chunk_c = signed'({1'b0, op_c[47:32]});
			default: chunk_c = signed'({op_c[63], op_c[63:48]});
		endcase
	end

	assign prod_c = coef_c * chunk_c;
	assign term_c = 128'(prod_s1) <<< {psh_s1, 4'b0000};

	always_comb begin
		case (j_q)
			2'd0:    acc_init_c = -(128'(cur_q[0]) <<< 16);
			default: acc_init_c = -(128'(cur_q[1]) <<< 17);
		endcase
	end

	assign mag_c = acc_q[127] ? -acc_q : acc_q;

	glp_div #(.KW(IW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DVS),
		.divisor(i_q + IW'(1)),
		.num    (mag_c[127:16]),
		.quo    (quo_c),
		.stat   (div_stat)
	);

	always_comb begin
		if (acc_q[127]) begin
			sat_ov_c = (quo_c[NUM_W-1:64] != '0) || (quo_c[63] && (quo_c[62:0] != '0));
			sat_c    = sat_ov_c ? {1'b1, 63'd0} : -signed'(quo_c[63:0]);
		end else begin
			sat_ov_c = (quo_c[NUM_W-1:63] != '0);
			sat_c    = sat_ov_c ? {1'b0, {63{1'b1}}} : signed'(quo_c[63:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			alpha_q     <= '0;
			out_valid_q <= 1'b0;
			pv_s1       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				alpha_q <= cfg_data;
			end
			if ((state_q == ST_SEL) && !(i_q < n_q) && out_free_c) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			pv_s1 <= (state_q == ST_MUL) && (mcnt_q < 4'd8);
			case (state_q)
				ST_IDLE: begin
					if (in_acc_c) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (i_q < n_q) begin
						state_q <= ST_MUL;
					end else if (out_free_c) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (mcnt_q == 4'd8) begin
						state_q <= ST_DVS;
					end
				end
				ST_DVS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= (j_q == 2'd2) ? ST_SEL : ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		psh_s1  <= mcnt_q[1:0];
		psub_s1 <= mcnt_q[2];
		case (state_q)
			ST_IDLE: begin
				if (in_acc_c) begin
					x_q      <= s_axis_tdata[31:0];
					n_q      <= n_c;
					i_q      <= IW'(1);
					ov_q     <= 1'b0;
					prv_q[0] <= 64'sd1 <<< 32;
					prv_q[1] <= '0;
					prv_q[2] <= '0;
					cur_q[2] <= '0;
					if (n_c == '0) begin
						cur_q[0] <= 64'sd1 <<< 32;
						cur_q[1] <= '0;
					end else begin
						cur_q[0] <= (64'(a_ext_c) + 64'sd65536
						           - 64'(signed'({1'b0, s_axis_tdata[31:0]}))) <<< 16;
						cur_q[1] <= -(64'sd1 <<< 32);
					end
				end
			end
			ST_SEL: begin
				c_q    <= 35'(signed'({1'b0, i_q, 1'b1, 16'd0})) + a_ext_c - x_ext_c;
				d_q    <= 35'(signed'({1'b0, i_q, 16'd0})) + a_ext_c;
				j_q    <= 2'd0;
				mcnt_q <= '0;
				acc_q  <= '0;
				if (!(i_q < n_q) && out_free_c) begin
					out_data_q <= {cur_q[2], cur_q[1], cur_q[0]};
					out_ov_q   <= ov_q;
				end
			end
			ST_MUL: begin
				mcnt_q <= mcnt_q + 4'd1;
				if (pv_s1) begin
					acc_q <= psub_s1 ? acc_q - term_c : acc_q + term_c;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					nxt_q[j_q] <= sat_c;
					ov_q       <= ov_q | sat_ov_c;
					mcnt_q     <= '0;
					if (j_q == 2'd2) begin
						for (int v = 0; v < 3; v++) begin
							prv_q[v] <= cur_q[v];
						end
						cur_q[0] <= nxt_q[0];
						cur_q[1] <= nxt_q[1];
						cur_q[2] <= sat_c;
						i_q      <= i_q + IW'(1);
					end else begin
						j_q   <= j_q + 2'd1;
						acc_q <= acc_init_c;
					end
				end
			end
			default: begin
			end
		endcase
	end

	`GLP_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV, "divider done outside divide")
	`GLP_ASSERT_NXT(a_accept_starts, in_acc_c, state_q == ST_SEL, "accepted item did not start")
	`GLP_ASSERT_IMP(a_step_bound, state_q != ST_IDLE, i_q <= n_q || n_q == '0, "step beyond order")
	`GLP_ASSERT_IMP(a_out_from_sel, $rose(m_axis_tvalid), $past(state_q == ST_SEL), "result without step")
endmodule

// File: hdl/glp_cell.sv
// ---------------------------------------------------------------------------
// glp_cell
// One byte cell of the divider row: loads a byte or takes its neighbor's.
// ---------------------------------------------------------------------------
module glp_cell (
	input  logic       clk,
	input  logic       load,
	input  logic       shift,
	input  logic [7:0] load_byte,
	input  logic [7:0] prev_byte,
	output logic [7:0] byte_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= load_byte;
		end else if (shift) begin
			byte_q <= prev_byte;
		end
	end
endmodule

// File: hdl/glp_div.sv
// ---------------------------------------------------------------------------
// glp_div
// Unsigned divide of a wide numerator by a small integer, one byte a cycle,
// through a row of byte cells that shift toward the head.
// ---------------------------------------------------------------------------
module glp_div #(
	parameter int KW = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [KW-1:0]           divisor,
	input  logic [glp_pkg::NUM_W-1:0] num,
	output logic [glp_pkg::NUM_W-1:0] quo,
	output glp_pkg::glp_div_stat_t  stat
);
	import glp_pkg::*;

	localparam int CW = $clog2(NUM_BYTES + 1);

	logic [7:0]    cell_q [NUM_BYTES];
	logic [7:0]    qbyte_c;
	logic [KW-1:0] rem_q;
	logic [KW-1:0] rem_c;
	logic [KW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          shift_c;

	assign shift_c = (cnt_q != '0);

	always_comb begin
		logic [KW:0] r2;
		r2    = '0;
		rem_c = rem_q;
		for (int b = 7; b >= 0; b--) begin
			r2 = {rem_c, cell_q[NUM_BYTES-1][b]};
			if (r2 >= {1'b0, k_q}) begin
				r2         = r2 - {1'b0, k_q};
				qbyte_c[b] = 1'b1;
			end else begin
				qbyte_c[b] = 1'b0;
			end
			rem_c = r2[KW-1:0];
		end
	end

	for (genvar m = 0; m < NUM_BYTES; m++) begin : g_row
		logic [7:0] prev_c;
		if (m == 0) begin : g_tail
			assign prev_c = qbyte_c;
		end else begin : g_body
			assign prev_c = cell_q[m-1];
		end
		glp_cell u_cell (
			.clk      (clk),
			.load     (start),
			.shift    (shift_c),
			.load_byte(num[8*m +: 8]),
			.prev_byte(prev_c),
			.byte_q   (cell_q[m])
		);
		assign quo[8*m +: 8] = cell_q[m];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NUM_BYTES);
			end else if (shift_c) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			k_q   <= divisor;
		end else if (shift_c) begin
			rem_q <= rem_c;
		end
	end

	assign stat.busy = shift_c;
	assign stat.done = done_q;
endmodule

// File: bench/gen_laguerre_poly_eval_top_tb.sv
// ---------------------------------------------------------------------------
// gen_laguerre_poly_eval_top_tb
// Drives points and orders into the Laguerre evaluator under several alpha
// settings, predicts value, first and second derivative and the overflow
// flag with a 128-bit recurrence of its own, and compares every result.
// ---------------------------------------------------------------------------
module gen_laguerre_poly_eval_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ORDER_CAP  = glp_pkg::MAX_ORDER_DEF;
	localparam int STALL_LIMIT = 8000;

	typedef struct {
		logic [31:0] x_point;
		logic [4:0]  poly_order;
	} point_t;

	typedef struct {
		logic [63:0] poly_value;
		logic [63:0] first_derivative;
		logic [63:0] second_derivative;
		logic        overflow;
	} laguerre_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	point_t    pend_q[$];
	laguerre_t poly_q[$];
	longint    alpha_q16 = 0;
	int        err_cnt = 0;
	bit        in_acc = 0;
	bit        calm = 0;
	bit        hold_req = 0;
	int        send_gap = 0;
	int        recv_gap = 0;
	int        hold_cnt = 0;
	int        quiet_cnt = 0;

	gen_laguerre_poly_eval_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic longint step_div(logic signed [127:0] num, longint dv, inout bit ov);
		logic signed [127:0] q;
		logic signed [127:0] dw;
		dw = dv;
		q = num / dw;
		if (q > 128'sh7fffffffffffffff) begin
			ov = 1;
			return 64'sh7fffffffffffffff;
		end
		if (q < -128'sh8000000000000000) begin
			ov = 1;
			return 64'sh8000000000000000;
		end
		return longint'(q);
	endfunction

	function automatic laguerre_t laguerre_eval(point_t p, longint alpha);
		laguerre_t r;
		longint x, c, d, v0, v1, v2, g0, g1, g2, h0, h1, h2;
		logic signed [127:0] cw, dw, nv, ng, nh;
		int n;
		bit ov;
		x = longint'({32'd0, p.x_point});
		n = (p.poly_order > ORDER_CAP) ? ORDER_CAP : int'(p.poly_order);
		ov = 0;
		v0 = 64'sd1 <<< 32; g0 = 0; h0 = 0;
		v1 = (65536 + alpha - x) * 65536;
		g1 = -(64'sd1 <<< 32); h1 = 0;
		if (n == 0) begin
			v1 = v0; g1 = g0; h1 = h0;
		end
		for (int i = 1; i < n; i++) begin
			c = longint'(2 * i + 1) * 65536 + alpha - x;
			d = longint'(i) * 65536 + alpha;
			cw = c;
			dw = d;
			nv = cw * v1 - dw * v0;
			ng = cw * g1 - 128'(v1) * 65536 - dw * g0;
			nh = cw * h1 - 128'(g1) * 131072 - dw * h0;
			v2 = step_div(nv, longint'(i + 1) * 65536, ov);
			g2 = step_div(ng, longint'(i + 1) * 65536, ov);
			h2 = step_div(nh, longint'(i + 1) * 65536, ov);
			v0 = v1; v1 = v2;
			g0 = g1; g1 = g2;
			h0 = h1; h1 = h2;
		end
		r.poly_value = v1;
		r.first_derivative = g1;
		r.second_derivative = h1;
		r.overflow = ov;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		err_cnt++;
	endtask

	// monitor: prediction on input transactions, checks on output transactions
	always @(posedge clk) begin
		laguerre_t want;
		in_acc = s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				alpha_q16 = longint'($signed(cfg_data));
			if (in_acc)
				poly_q.push_back(laguerre_eval('{s_axis_tdata[31:0], s_axis_tdata[36:32]},
					alpha_q16));
			if (m_axis_tvalid && m_axis_tready) begin
				if (poly_q.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
				end else begin
					want = poly_q.pop_front();
					if (m_axis_tdata[63:0] !== want.poly_value)
						report_mismatch("poly_value", m_axis_tdata[63:0], want.poly_value);
					if (m_axis_tdata[127:64] !== want.first_derivative)
						report_mismatch("first_derivative", m_axis_tdata[127:64],
							want.first_derivative);
					if (m_axis_tdata[191:128] !== want.second_derivative)
						report_mismatch("second_derivative", m_axis_tdata[191:128],
							want.second_derivative);
					if (m_axis_tuser[0] !== want.overflow)
						report_mismatch("overflow", 64'(m_axis_tuser), 64'(want.overflow));
				end
			end
			if (in_acc || (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
				quiet_cnt = 0;
			else
				quiet_cnt++;
			if (quiet_cnt >= STALL_LIMIT) begin
				$display("gen_laguerre_poly_eval_top_tb NOT OK");
				$finish;
			end
		end
	end

	// driver
	always @(negedge clk) begin
		point_t p;
		if (arst_n && (!s_axis_tvalid || in_acc)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				p = pend_q.pop_front();
				s_axis_tdata <= {3'b0, p.poly_order, p.x_point};
				s_axis_tvalid <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 6);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 600;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 6);
			end
		end
	end

	function automatic point_t rand_point();
		point_t p;
		int pick;
		pick = $urandom_range(0, 9);
		p.x_point = (pick < 5) ? 32'($urandom_range(0, 24 << 16)) : $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			p.poly_order = 5'($urandom_range(0, 6));
		else if (pick < 94)
			p.poly_order = 5'($urandom_range(7, 16));
		else
			p.poly_order = 5'($urandom_range(17, 31));
		return p;
	endfunction

	task automatic drain();
		while (pend_q.size() > 0 || s_axis_tvalid || poly_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_alpha(logic [31:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] alphas[5];
		logic [4:0]  orders[6];
		alphas = '{32'h0000_0000, 32'hffff_0001, 32'h7fff_ffff, 32'h0001_8000, 32'h0000_0000};
		orders = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (alphas[ph]) begin
			alphas[ph] = (ph == 3) ? 32'($urandom_range(0, 32'h0010_0000)) : alphas[ph];
			write_alpha(alphas[ph]);
			if (ph == 0) begin
				foreach (orders[k]) begin
					pend_q.push_back('{32'h0000_0000, orders[k]});
					pend_q.push_back('{32'hffff_ffff, orders[k]});
					pend_q.push_back('{32'h0001_0000, orders[k]});
				end
				pend_q.push_back('{32'h0000_0001, 5'd3});
				pend_q.push_back('{32'h8000_0000, 5'd4});
			end
			calm = (ph == 4);
			for (int k = 0; k < 260; k++)
				pend_q.push_back(rand_point());
			if (ph == 1) begin
				repeat (20) @(posedge clk);
				hold_req = 1;
				for (int k = 0; k < 6; k++)
					pend_q.push_back('{32'($urandom), 5'd1});
			end
			drain();
		end
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("gen_laguerre_poly_eval_top_tb OK");
		else
			$display("gen_laguerre_poly_eval_top_tb NOT OK");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hdl
hdl/glp_pkg.sv
hdl/glp_cell.sv
hdl/glp_div.sv
hdl/gen_laguerre_poly_eval_top.sv
bench/gen_laguerre_poly_eval_top_tb.sv
